FILE: hdl/kwrm_pkg.sv
// Package for the k-way run merge block: sizes of the value store and the run heads.
// No dependencies. Used by k_way_run_merge_top.
`timescale 1ns / 1ps

package kwrm_pkg;

   // Number of sorted runs and their common length.
   localparam int RUNS    = 8;
   localparam int RUN_LEN = 64;
   localparam int TOTAL   = RUNS * RUN_LEN;

   // Derived widths.
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = $clog2(TOTAL);
   localparam int COUNT_W = $clog2(TOTAL + 1);
   localparam int RUN_W   = $clog2(RUNS);
   localparam int HEAD_W  = $clog2(RUN_LEN + 1);
   localparam int OFF_W   = (RUN_LEN > 1) ? $clog2(RUN_LEN) : 1;

   // Input item kinds carried on req_tuser.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TAKE = 1'b1;

   typedef logic signed [DATA_W-1:0] value_type;
   typedef logic [HEAD_W-1:0]        head_type;
   typedef logic [RUN_W-1:0]         run_type;

endpackage

FILE: hdl/k_way_run_merge_top.sv
// Top level of the k-way run merge: value store, run head registers and take logic.
// Depends on kwrm_pkg for sizes and types.
`timescale 1ns / 1ps

// Merges RUNS ascending runs of RUN_LEN signed 32-bit values each. Load items (req_tuser = 0)
// write values into the store in order, run 0 first; the first value of each run is also
// captured in a head register. Once the store is full, each take item (req_tuser = 1) returns
// the smallest head (ties to the lowest run) with rsp_tuser = 1, and rsp_tlast marks the final
// value, after which the block is empty and takes a new data set. A take while the store is
// not full returns rsp_tuser = 0 with zero data. Loads into a full store are dropped. When
// the chosen run of a take still has values, its next value is read from the store into a
// read register and then written into the head register; no item is accepted while this
// refill runs. The store needs no clearing after reset.
module k_way_run_merge_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_value
   output logic        rsp_tuser,   // [0] valid_res
   output logic        rsp_tlast
);

   // Value store, one write port for loads and one read port for head refills.
   logic [kwrm_pkg::DATA_W-1:0] store_mem [kwrm_pkg::TOTAL];
   logic [kwrm_pkg::DATA_W-1:0] rd_data_ff;

   // Control counters.
   logic [kwrm_pkg::COUNT_W-1:0] load_count_ff, load_count_in;
   logic [kwrm_pkg::COUNT_W-1:0] emitted_count_ff, emitted_count_in;
   logic [kwrm_pkg::OFF_W-1:0]   load_off_ff, load_off_in;
   kwrm_pkg::run_type            load_run_ff, load_run_in;

   // Head offsets and registered head values of each run.
   kwrm_pkg::head_type  run_heads_ff [kwrm_pkg::RUNS];
   kwrm_pkg::value_type head_val_ff  [kwrm_pkg::RUNS];

   // Pending refill of one head from the store.
   logic              refill_ff, refill_in;
   kwrm_pkg::run_type refill_run_ff, refill_run_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   kwrm_pkg::value_type rsp_data_ff, rsp_data_in;
   logic                rsp_flag_ff, rsp_flag_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                        req_ready;
   logic                        accept;
   logic                        do_load;
   logic                        do_take;
   logic                        load_full;
   logic                        found;
   kwrm_pkg::run_type           best_run;
   kwrm_pkg::value_type         best_val;
   kwrm_pkg::head_type          next_head;
   logic                        need_refill;
   logic                        last_take;
   logic [kwrm_pkg::ADDR_W-1:0] rd_addr;

   // Handshake: hold off while a head refill is under way or the result cannot move on.
   assign req_ready  = !refill_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = req_ready;
   assign accept     = req_tvalid && req_ready;
   assign load_full  = (load_count_ff == kwrm_pkg::COUNT_W'(kwrm_pkg::TOTAL));
   assign do_load    = accept && (req_tuser == kwrm_pkg::MODE_LOAD) && !load_full;
   assign do_take    = accept && (req_tuser == kwrm_pkg::MODE_TAKE);

   // Pick the smallest head among the runs that still hold values; ties go to the lowest run.
   always_comb begin
      found    = 1'b0;
      best_run = '0;
      best_val = '0;
      for (int r = 0; r < kwrm_pkg::RUNS; r++) begin
         if (run_heads_ff[r] != kwrm_pkg::HEAD_W'(kwrm_pkg::RUN_LEN) &&
             (!found || head_val_ff[r] < best_val)) begin
            found    = 1'b1;
            best_run = kwrm_pkg::RUN_W'(r);
            best_val = head_val_ff[r];
         end
      end
   end

   // Next offset of the chosen run and the store address of its next value.
   assign next_head   = run_heads_ff[best_run] + kwrm_pkg::HEAD_W'(1);
   assign need_refill = (next_head != kwrm_pkg::HEAD_W'(kwrm_pkg::RUN_LEN));
   assign last_take   = (emitted_count_ff == kwrm_pkg::COUNT_W'(kwrm_pkg::TOTAL - 1));
   assign rd_addr     = kwrm_pkg::ADDR_W'(best_run) * kwrm_pkg::ADDR_W'(kwrm_pkg::RUN_LEN)
                      + kwrm_pkg::ADDR_W'(next_head);

   // Next-state logic for counters, refill control and the output register.
   always_comb begin
      load_count_in    = load_count_ff;
      emitted_count_in = emitted_count_ff;
      load_off_in      = load_off_ff;
      load_run_in      = load_run_ff;
      refill_in        = 1'b0;
      refill_run_in    = refill_run_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      rsp_flag_in      = rsp_flag_ff;
      rsp_last_in      = rsp_last_ff;

      if (do_load) begin
         load_count_in = load_count_ff + kwrm_pkg::COUNT_W'(1);
         if (load_off_ff == kwrm_pkg::OFF_W'(kwrm_pkg::RUN_LEN - 1)) begin
            load_off_in = '0;
            if (load_run_ff == kwrm_pkg::RUN_W'(kwrm_pkg::RUNS - 1)) begin
               load_run_in = '0;
            end else begin
               load_run_in = load_run_ff + kwrm_pkg::RUN_W'(1);
            end
         end else begin
            load_off_in = load_off_ff + kwrm_pkg::OFF_W'(1);
         end
      end

      if (do_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_flag_in  = 1'b0;
         rsp_last_in  = 1'b0;
         if (load_full && found) begin
            rsp_data_in = best_val;
            rsp_flag_in = 1'b1;
            if (last_take) begin
               rsp_last_in      = 1'b1;
               load_count_in    = '0;
               emitted_count_in = '0;
            end else begin
               emitted_count_in = emitted_count_ff + kwrm_pkg::COUNT_W'(1);
               refill_in        = need_refill;
               refill_run_in    = best_run;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff    <= '0;
         emitted_count_ff <= '0;
         load_off_ff      <= '0;
         load_run_ff      <= '0;
         refill_ff        <= 1'b0;
         refill_run_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         load_count_ff    <= load_count_in;
         emitted_count_ff <= emitted_count_in;
         load_off_ff      <= load_off_in;
         load_run_ff      <= load_run_in;
         refill_ff        <= refill_in;
         refill_run_ff    <= refill_run_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Run head offsets: advance on a take from a full store, all return to zero after the final value.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < kwrm_pkg::RUNS; r++) begin
            run_heads_ff[r] <= '0;
         end
      end else if (do_take && load_full && found) begin
         if (last_take) begin
            for (int r = 0; r < kwrm_pkg::RUNS; r++) begin
               run_heads_ff[r] <= '0;
            end
         end else begin
            run_heads_ff[best_run] <= next_head;
         end
      end
   end

   // Head values: first value of a run during loading, store read data on a refill.
   always_ff @(posedge clock) begin
      if (do_load && load_off_ff == '0) begin
         head_val_ff[load_run_ff] <= req_tdata;
      end else if (refill_ff) begin
         head_val_ff[refill_run_ff] <= rd_data_ff;
      end
   end

   // Store write and registered read.
   always_ff @(posedge clock) begin
      if (do_load) begin
         store_mem[load_count_ff[kwrm_pkg::ADDR_W-1:0]] <= req_tdata;
      end
      if (refill_in) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A refill lasts exactly one cycle and blocks new items while it runs.
   assert property (@(posedge clock) disable iff (reset) refill_ff |=> !refill_ff)
      else $error("head refill lasted more than one cycle");

   assert property (@(posedge clock) disable iff (reset) refill_ff |-> !req_tready)
      else $error("item accepted during a head refill");

   // Merging only goes on over a full store.
   assert property (@(posedge clock) disable iff (reset)
      (emitted_count_ff != '0) |-> load_full)
      else $error("values emitted from a store that is not full");

   // The final marker only comes with an emitted value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_flag_ff)
      else $error("final marker on an empty result");

endmodule
